// ===== hdl/sthr_pkg.sv =====
// Shared types, constants and the scan code ROM for the scancode to HID report block.
// No dependencies.
`default_nettype none

package sthr_pkg;

	localparam int KEY_SLOTS  = 6;
	localparam int CODE_LIMIT = 85;
	localparam int OUT_SLOTS  = 6;
	localparam int SLOT_IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	localparam logic [7:0] FN_BIT = 8'h08;

	typedef struct packed {
		logic [7:0] main_key;
		logic [7:0] fn_key;
		logic [7:0] fn_mod;
		logic [7:0] mod;
	} rom_entry_t;

	typedef struct packed {
		logic load_frame;
		logic decode;
		logic scan_clr;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic parity_ok;
		logic need_scan;
		logic scan_done;
		logic out_free;
	} status_t;

	function automatic rom_entry_t code_rom(input logic [6:0] code);
		rom_entry_t e;
		e = '0;
		case (code)
			7'h01: e = '{8'h29, 8'h00, 8'h00, 8'h00};
			7'h02: e = '{8'h1E, 8'h3A, 8'h00, 8'h00};
			7'h03: e = '{8'h1F, 8'h3B, 8'h00, 8'h00};
			7'h04: e = '{8'h20, 8'h3C, 8'h00, 8'h00};
			7'h05: e = '{8'h21, 8'h3D, 8'h00, 8'h00};
			7'h06: e = '{8'h22, 8'h3E, 8'h00, 8'h00};
			7'h07: e = '{8'h23, 8'h3F, 8'h00, 8'h00};
			7'h08: e = '{8'h24, 8'h40, 8'h00, 8'h00};
			7'h09: e = '{8'h25, 8'h41, 8'h00, 8'h00};
			7'h0A: e = '{8'h26, 8'h42, 8'h00, 8'h00};
			7'h0B: e = '{8'h27, 8'h43, 8'h00, 8'h00};
			7'h0C: e = '{8'h2D, 8'h00, 8'h00, 8'h00};
			7'h0D: e = '{8'h2E, 8'h00, 8'h00, 8'h00};
			7'h0E: e = '{8'h2A, 8'h00, 8'h00, 8'h00};
			7'h0F: e = '{8'h2B, 8'h00, 8'h00, 8'h00};
			7'h10: e = '{8'h14, 8'h48, 8'h00, 8'h00};
			7'h11: e = '{8'h1A, 8'h00, 8'h00, 8'h00};
			7'h12: e = '{8'h08, 8'h00, 8'h00, 8'h00};
			7'h13: e = '{8'h15, 8'h00, 8'h00, 8'h00};
			7'h14: e = '{8'h17, 8'h00, 8'h00, 8'h00};
			7'h15: e = '{8'h1C, 8'h00, 8'h00, 8'h00};
			7'h16: e = '{8'h18, 8'h00, 8'h00, 8'h00};
			7'h17: e = '{8'h0C, 8'h00, 8'h00, 8'h00};
			7'h18: e = '{8'h12, 8'h00, 8'h00, 8'h00};
			7'h19: e = '{8'h13, 8'h46, 8'h00, 8'h00};
			7'h1A: e = '{8'h2F, 8'h31, 8'h02, 8'h00};
			7'h1B: e = '{8'h30, 8'h35, 8'h02, 8'h00};
			7'h1C: e = '{8'h28, 8'h00, 8'h00, 8'h00};
			7'h1D: e = '{8'h00, 8'h00, 8'h00, 8'h01};
			7'h1E: e = '{8'h04, 8'h00, 8'h00, 8'h00};
			7'h1F: e = '{8'h16, 8'h47, 8'h00, 8'h00};
			7'h20: e = '{8'h07, 8'h00, 8'h00, 8'h00};
			7'h21: e = '{8'h09, 8'h00, 8'h00, 8'h00};
			7'h22: e = '{8'h0A, 8'h00, 8'h00, 8'h00};
			7'h23: e = '{8'h0B, 8'h00, 8'h00, 8'h00};
			7'h24: e = '{8'h0D, 8'h00, 8'h00, 8'h00};
			7'h25: e = '{8'h0E, 8'h00, 8'h00, 8'h00};
			7'h26: e = '{8'h0F, 8'h00, 8'h00, 8'h00};
			7'h27: e = '{8'h33, 8'h00, 8'h00, 8'h00};
			7'h28: e = '{8'h34, 8'h35, 8'h00, 8'h00};
			7'h2A: e = '{8'h00, 8'h00, 8'h00, 8'h02};
			7'h2C: e = '{8'h1D, 8'h00, 8'h00, 8'h00};
			7'h2D: e = '{8'h1B, 8'h00, 8'h00, 8'h00};
			7'h2E: e = '{8'h06, 8'h00, 8'h00, 8'h00};
			7'h2F: e = '{8'h19, 8'h00, 8'h00, 8'h00};
			7'h30: e = '{8'h05, 8'h00, 8'h00, 8'h00};
			7'h31: e = '{8'h11, 8'h00, 8'h00, 8'h00};
			7'h32: e = '{8'h10, 8'h00, 8'h00, 8'h00};
			7'h33: e = '{8'h36, 8'h00, 8'h00, 8'h00};
			7'h34: e = '{8'h37, 8'h00, 8'h00, 8'h00};
			7'h35: e = '{8'h38, 8'h31, 8'h00, 8'h00};
			7'h36: e = '{8'h00, 8'h00, 8'h00, 8'h20};
			7'h38: e = '{8'h00, 8'h00, 8'h00, 8'h04};
			7'h39: e = '{8'h2C, 8'h00, 8'h00, 8'h00};
			7'h3A: e = '{8'h39, 8'h00, 8'h00, 8'h00};
			7'h48: e = '{8'h52, 8'h4A, 8'h00, 8'h00};
			7'h4B: e = '{8'h50, 8'h4B, 8'h00, 8'h00};
			7'h4D: e = '{8'h4F, 8'h4E, 8'h00, 8'h00};
			7'h50: e = '{8'h51, 8'h4D, 8'h00, 8'h00};
			7'h52: e = '{8'h49, 8'h00, 8'h00, 8'h00};
			7'h53: e = '{8'h4C, 8'h00, 8'h00, 8'h00};
			7'h54: e = '{8'h00, 8'h00, 8'h00, 8'h08};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/sthr_ctrl.sv =====
// Controller state machine: sequences decode, slot scan and report load.
// Depends on sthr_pkg.
`default_nettype none

module sthr_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                frame_valid,
	output logic               frame_ready,
	input  sthr_pkg::status_t  status,
	output sthr_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign frame_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.load_frame = (state_q == ST_IDLE) && frame_valid;
		cmd.decode     = (state_q == ST_DECODE);
		cmd.scan_clr   = (state_q == ST_DECODE);
		cmd.scan_step  = (state_q == ST_SCAN);
		cmd.emit       = (state_q == ST_EMIT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (frame_valid)
						state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (!status.parity_ok)
						state_q <= ST_IDLE;
					else if (status.need_scan)
						state_q <= ST_SCAN;
					else
						state_q <= ST_EMIT;
				end
				ST_SCAN: begin
					if (status.scan_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/sthr_dp.sv =====
// Datapath: frame register, ROM decode, modifier and fn-layer state, key slots
// with a one-slot-per-cycle scan, and the report output register. Depends on sthr_pkg.
`default_nettype none

module sthr_dp (
	input  wire                clk,
	input  wire                arst_n,
	input  wire  [8:0]         frame_bits,
	input  sthr_pkg::cmd_t     cmd,
	output sthr_pkg::status_t  status,
	input  wire                report_ready,
	output logic               report_valid,
	output logic [7:0]         rpt_mod,
	output logic [sthr_pkg::OUT_SLOTS-1:0][7:0] rpt_slots
);

	localparam logic [sthr_pkg::SLOT_IDX_W-1:0] LAST_IDX =
		sthr_pkg::SLOT_IDX_W'(sthr_pkg::KEY_SLOTS - 1);

	logic [8:0]  frame_q;
	logic [7:0]  held_q;
	logic [7:0]  fn_q;
	logic [7:0]  key_q;
	logic        rel_q;
	logic [7:0]  slots_q [sthr_pkg::KEY_SLOTS];
	logic [sthr_pkg::SLOT_IDX_W-1:0] idx_q;
	logic        out_valid_q;
	logic [7:0]  rpt_mod_q;
	logic [sthr_pkg::OUT_SLOTS-1:0][7:0] rpt_slots_q;

	sthr_pkg::rom_entry_t entry;
	logic [6:0] code;
	logic       release_bit;
	logic       in_range;
	logic       is_fn;
	logic       is_mod;
	logic [7:0] key_d;
	logic [7:0] held_d;
	logic [7:0] fn_d;
	logic [7:0] fn_or;
	logic [7:0] cur_slot;
	logic       slot_hit;
	logic       slot_wr;
	logic [7:0] slot_wdata;

	assign code        = frame_q[6:0];
	assign release_bit = frame_q[7];
	assign entry       = sthr_pkg::code_rom(code);
	assign in_range    = ({1'b0, code} < 8'(sthr_pkg::CODE_LIMIT));
	assign is_fn       = (entry.mod == sthr_pkg::FN_BIT);
	assign is_mod      = (entry.mod != 8'h00) && !is_fn;
	assign fn_or       = fn_q | entry.fn_mod;

	always_comb begin
		key_d  = entry.main_key;
		held_d = held_q;
		fn_d   = fn_q;
		if (is_fn) begin
			fn_d = release_bit ? 8'h00 : sthr_pkg::FN_BIT;
		end else if (is_mod) begin
			held_d = release_bit ? (held_q & ~entry.mod) : (held_q | entry.mod);
		end else if (release_bit) begin
			if (fn_q != 8'h00) begin
				key_d  = entry.fn_key;
				held_d = held_q & ~(fn_q & ~sthr_pkg::FN_BIT);
			end
		end else begin
			if ((fn_q & sthr_pkg::FN_BIT) != 8'h00) begin
				key_d  = entry.fn_key;
				fn_d   = fn_or;
				held_d = held_q | (fn_or & ~sthr_pkg::FN_BIT);
			end
		end
	end

	// one slot per cycle
	assign cur_slot = slots_q[idx_q];

	always_comb begin
		if (rel_q) begin
			slot_hit   = (cur_slot == key_q);
			slot_wr    = slot_hit;
			slot_wdata = 8'h00;
		end else begin
			slot_hit   = (cur_slot == 8'h00) || (cur_slot == key_q);
			slot_wr    = (cur_slot == 8'h00);
			slot_wdata = key_q;
		end
	end

	assign status.parity_ok = ^frame_q;
	assign status.need_scan = in_range && (entry.mod == 8'h00);
	assign status.scan_done = slot_hit || (idx_q == LAST_IDX);
	assign status.out_free  = !out_valid_q || report_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_frame)
			frame_q <= frame_bits;
		if (cmd.decode) begin
			key_q <= key_d;
			rel_q <= release_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			fn_q   <= '0;
			idx_q  <= '0;
			for (int i = 0; i < sthr_pkg::KEY_SLOTS; i++)
				slots_q[i] <= '0;
		end else begin
			if (cmd.decode && status.parity_ok && in_range) begin
				held_q <= held_d;
				fn_q   <= fn_d;
			end
			if (cmd.scan_clr)
				idx_q <= '0;
			else if (cmd.scan_step && !status.scan_done)
				idx_q <= idx_q + sthr_pkg::SLOT_IDX_W'(1);
			if (cmd.scan_step && slot_wr)
				slots_q[idx_q] <= slot_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (report_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rpt_mod_q <= held_q;
			for (int i = 0; i < sthr_pkg::OUT_SLOTS; i++)
				rpt_slots_q[i] <= (i < sthr_pkg::KEY_SLOTS) ? slots_q[i] : 8'h00;
		end
	end

	assign report_valid = out_valid_q;
	assign rpt_mod      = rpt_mod_q;
	assign rpt_slots    = rpt_slots_q;

endmodule

`default_nettype wire

// ===== hdl/scancode_to_hid_report_core.sv =====
// Top level: keyboard frame in, HID boot report out. Depends on sthr_pkg,
// sthr_ctrl and sthr_dp.
// Sequence: the frame is decoded first; modifier keys and codes out of range go
// straight to emit, while plain keys first scan the key slots (slot scan,
// one slot per cycle). A new frame is taken only in idle, after the last one is done; a bad-parity
// frame gives no report; emit waits while a report is still pending.
// Reset: arst_n clears modifiers, fn layer, all key slots and the output valid.
`default_nettype none

module scancode_to_hid_report_core (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        frame_valid,
	output logic       frame_ready,
	input  wire  [8:0] frame_bits,
	output logic       report_valid,
	input  wire        report_ready,
	output logic [7:0] modifier_byte,
	output logic [7:0] key_slot_a,
	output logic [7:0] key_slot_b,
	output logic [7:0] key_slot_c,
	output logic [7:0] key_slot_d,
	output logic [7:0] key_slot_e,
	output logic [7:0] key_slot_f
);

	sthr_pkg::cmd_t    cmd;
	sthr_pkg::status_t status;
	logic [sthr_pkg::OUT_SLOTS-1:0][7:0] rpt_slots;

	sthr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.status      (status),
		.cmd         (cmd)
	);

	sthr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_bits   (frame_bits),
		.cmd          (cmd),
		.status       (status),
		.report_ready (report_ready),
		.report_valid (report_valid),
		.rpt_mod      (modifier_byte),
		.rpt_slots    (rpt_slots)
	);

	assign key_slot_a = rpt_slots[0];
	assign key_slot_b = rpt_slots[1];
	assign key_slot_c = rpt_slots[2];
	assign key_slot_d = rpt_slots[3];
	assign key_slot_e = rpt_slots[4];
	assign key_slot_f = rpt_slots[5];

endmodule

`default_nettype wire

// ===== tb/scancode_to_hid_report_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for scancode_to_hid_report_core: keyboard frames in, HID reports out,
// each report checked against a scoreboard that tracks modifiers, fn layer and slots.
// Depends on sthr_pkg and the scancode_to_hid_report_core RTL.

typedef struct packed {
	logic [7:0]      mods;
	logic [5:0][7:0] keys;
} hid_report_t;

class hid_report_scoreboard;
	bit [7:0]    held_mods;
	bit [7:0]    layer;
	bit [7:0]    slots[sthr_pkg::KEY_SLOTS];
	hid_report_t expected[$];
	int          errors;

	// {main usage, fn usage, fn modifier, modifier bit}
	function bit [31:0] keymap(bit [6:0] code);
		case (code)
			7'h01: return 32'h29000000;
			7'h02: return 32'h1E3A0000;
			7'h03: return 32'h1F3B0000;
			7'h04: return 32'h203C0000;
			7'h05: return 32'h213D0000;
			7'h06: return 32'h223E0000;
			7'h07: return 32'h233F0000;
			7'h08: return 32'h24400000;
			7'h09: return 32'h25410000;
			7'h0A: return 32'h26420000;
			7'h0B: return 32'h27430000;
			7'h0C: return 32'h2D000000;
			7'h0D: return 32'h2E000000;
			7'h0E: return 32'h2A000000;
			7'h0F: return 32'h2B000000;
			7'h10: return 32'h14480000;
			7'h11: return 32'h1A000000;
			7'h12: return 32'h08000000;
			7'h13: return 32'h15000000;
			7'h14: return 32'h17000000;
			7'h15: return 32'h1C000000;
			7'h16: return 32'h18000000;
			7'h17: return 32'h0C000000;
			7'h18: return 32'h12000000;
			7'h19: return 32'h13460000;
			7'h1A: return 32'h2F310200;
			7'h1B: return 32'h30350200;
			7'h1C: return 32'h28000000;
			7'h1D: return 32'h00000001;
			7'h1E: return 32'h04000000;
			7'h1F: return 32'h16470000;
			7'h20: return 32'h07000000;
			7'h21: return 32'h09000000;
			7'h22: return 32'h0A000000;
			7'h23: return 32'h0B000000;
			7'h24: return 32'h0D000000;
			7'h25: return 32'h0E000000;
			7'h26: return 32'h0F000000;
			7'h27: return 32'h33000000;
			7'h28: return 32'h34350000;
			7'h2A: return 32'h00000002;
			7'h2C: return 32'h1D000000;
			7'h2D: return 32'h1B000000;
			7'h2E: return 32'h06000000;
			7'h2F: return 32'h19000000;
			7'h30: return 32'h05000000;
			7'h31: return 32'h11000000;
			7'h32: return 32'h10000000;
			7'h33: return 32'h36000000;
			7'h34: return 32'h37000000;
			7'h35: return 32'h38310000;
			7'h36: return 32'h00000020;
			7'h38: return 32'h00000004;
			7'h39: return 32'h2C000000;
			7'h3A: return 32'h39000000;
			7'h48: return 32'h524A0000;
			7'h4B: return 32'h504B0000;
			7'h4D: return 32'h4F4E0000;
			7'h50: return 32'h514D0000;
			7'h52: return 32'h49000000;
			7'h53: return 32'h4C000000;
			7'h54: return 32'h00000008;
			default: return 32'h0;
		endcase
	endfunction

	function void press_slot(bit [7:0] k);
		bit done;
		done = 0;
		for (int i = 0; i < sthr_pkg::KEY_SLOTS; i++) begin
			if (!done && slots[i] == 8'h00) begin
				slots[i] = k;
				done = 1;
			end else if (!done && slots[i] == k) begin
				done = 1;
			end
		end
	endfunction

	function void release_slot(bit [7:0] k);
		bit done;
		done = 0;
		for (int i = 0; i < sthr_pkg::KEY_SLOTS; i++) begin
			if (!done && slots[i] == k) begin
				slots[i] = 8'h00;
				done = 1;
			end
		end
	endfunction

	function void apply_code(bit [6:0] code, bit rel);
		bit [7:0] main_key, fn_key, fn_mod, mod_bit, k;
		{main_key, fn_key, fn_mod, mod_bit} = keymap(code);
		if (mod_bit == sthr_pkg::FN_BIT) begin
			layer = rel ? 8'h00 : sthr_pkg::FN_BIT;
		end else if (mod_bit != 8'h00) begin
			held_mods = rel ? (held_mods & ~mod_bit) : (held_mods | mod_bit);
		end else if (rel) begin
			if (layer == 8'h00) begin
				k = main_key;
			end else begin
				k = fn_key;
				held_mods = held_mods & ~(layer & ~sthr_pkg::FN_BIT);
			end
			release_slot(k);
		end else begin
			if ((layer & sthr_pkg::FN_BIT) == 8'h00) begin
				k = main_key;
			end else begin
				k = fn_key;
				layer = layer | fn_mod;
				held_mods = held_mods | (layer & ~sthr_pkg::FN_BIT);
			end
			press_slot(k);
		end
	endfunction

	function void note_frame(bit [8:0] frame);
		hid_report_t r;
		if (^frame) begin
			if (frame[6:0] < sthr_pkg::CODE_LIMIT)
				apply_code(frame[6:0], frame[7]);
			r.mods = held_mods;
			for (int i = 0; i < 6; i++)
				r.keys[i] = (i < sthr_pkg::KEY_SLOTS) ? slots[i] : 8'h00;
			expected.push_back(r);
		end
	endfunction

	task report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task check_report(hid_report_t got);
		hid_report_t want;
		if (expected.size() == 0) begin
			report($sformatf("report %h with no request pending", got));
		end else begin
			want = expected.pop_front();
			if (got.mods !== want.mods)
				report($sformatf("modifier_byte %h, expected %h", got.mods, want.mods));
			for (int i = 0; i < 6; i++)
				if (got.keys[i] !== want.keys[i])
					report($sformatf("key slot %0d %h, expected %h", i, got.keys[i],
						want.keys[i]));
		end
	endtask
endclass

module scancode_to_hid_report_core_tb;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       frame_valid = 1'b0;
	logic [8:0] frame_bits = 9'h000;
	logic       report_ready = 1'b0;
	logic       frame_ready, report_valid;
	logic [7:0] modifier_byte;
	logic [7:0] key_slot_a, key_slot_b, key_slot_c, key_slot_d, key_slot_e, key_slot_f;

	hid_report_scoreboard sb = new;
	bit [6:0] plain_codes[$];
	bit [6:0] down_codes[$];
	bit [6:0] mod_codes[4] = '{7'h1D, 7'h2A, 7'h36, 7'h38};
	localparam bit [6:0] FN_CODE = 7'h54;
	int rx_cyc;

	scancode_to_hid_report_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame_bits   (frame_bits),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.modifier_byte(modifier_byte),
		.key_slot_a   (key_slot_a),
		.key_slot_b   (key_slot_b),
		.key_slot_c   (key_slot_c),
		.key_slot_d   (key_slot_d),
		.key_slot_e   (key_slot_e),
		.key_slot_f   (key_slot_f)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		if (arst_n) begin
			rx_cyc++;
			case ((rx_cyc / 256) % 4)
				0: report_ready <= 1'b1;
				1: report_ready <= ($urandom_range(0, 3) != 0);
				2: report_ready <= ((rx_cyc % 5) >= 2);
				default: report_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && report_valid && report_ready)
			sb.check_report({modifier_byte, key_slot_f, key_slot_e, key_slot_d,
				key_slot_c, key_slot_b, key_slot_a});
	end

	function automatic bit [8:0] frame_of(bit [6:0] code, bit rel, bit good);
		bit [7:0] b;
		b = {rel, code};
		return {(^b) ^ good, b};
	endfunction

	function automatic bit [8:0] pick_frame();
		bit [6:0] code;
		bit       rel, good;
		int       r, idx;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 9'($urandom_range(0, 511));
		good = (r >= 16);
		r = $urandom_range(0, 99);
		if (r < 12) begin
			code = FN_CODE;
			rel = 1'($urandom_range(0, 1));
		end else if (r < 25) begin
			code = mod_codes[$urandom_range(0, 3)];
			rel = 1'($urandom_range(0, 1));
		end else if (r < 32) begin
			code = 7'($urandom_range(0, 127));
			rel = 1'($urandom_range(0, 1));
		end else if (r < 40) begin
			code = plain_codes[$urandom_range(0, plain_codes.size() - 1)];
			rel = 1'b1;
		end else if (down_codes.size() > 0 && $urandom_range(0, 7) < down_codes.size()) begin
			idx = $urandom_range(0, down_codes.size() - 1);
			code = down_codes[idx];
			rel = 1'b1;
			if (good)
				down_codes.delete(idx);
		end else begin
			code = plain_codes[$urandom_range(0, plain_codes.size() - 1)];
			rel = 1'b0;
			if (good)
				down_codes.push_back(code);
		end
		return frame_of(code, rel, good);
	endfunction

	task automatic send_frame(bit [8:0] f);
		@(negedge clk);
		frame_valid <= 1'b1;
		frame_bits  <= f;
		do
			@(posedge clk);
		while (!frame_ready);
		sb.note_frame(f);
	endtask

	task automatic idle_sender(int n);
		@(negedge clk);
		frame_valid <= 1'b0;
		frame_bits  <= 9'($urandom_range(0, 511));
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain();
		idle_sender(1);
		while (sb.expected.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		bit [8:0]  directed[$];
		bit [8:0]  f;
		bit [31:0] km;
		int        n;

		for (int c = 0; c < sthr_pkg::CODE_LIMIT; c++) begin
			km = sb.keymap(7'(c));
			if (km != 32'h0 && km[7:0] == 8'h00)
				plain_codes.push_back(7'(c));
		end

		directed = '{9'h000, 9'h1FF, frame_of(7'h55, 1'b0, 1'b1),
			frame_of(7'h7F, 1'b0, 1'b1), frame_of(7'h1D, 1'b0, 1'b1),
			frame_of(7'h36, 1'b0, 1'b1), frame_of(7'h02, 1'b0, 1'b1),
			frame_of(7'h02, 1'b0, 1'b1), frame_of(7'h00, 1'b0, 1'b1),
			frame_of(7'h29, 1'b0, 1'b1), frame_of(7'h10, 1'b0, 1'b1),
			frame_of(7'h11, 1'b0, 1'b1), frame_of(7'h12, 1'b0, 1'b1),
			frame_of(7'h13, 1'b0, 1'b1), frame_of(7'h14, 1'b0, 1'b1),
			frame_of(7'h15, 1'b0, 1'b1), frame_of(7'h11, 1'b1, 1'b1),
			frame_of(7'h1E, 1'b0, 1'b1), frame_of(FN_CODE, 1'b0, 1'b1),
			frame_of(7'h1A, 1'b0, 1'b0), frame_of(7'h13, 1'b1, 1'b1),
			frame_of(7'h1A, 1'b0, 1'b1), frame_of(7'h1A, 1'b1, 1'b1),
			frame_of(FN_CODE, 1'b1, 1'b1), frame_of(7'h1D, 1'b1, 1'b1)};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_frame(directed[i]);
		drain();

		n = 0;
		while (n < 750) begin
			repeat ($urandom_range(1, 16)) begin
				f = pick_frame();
				send_frame(f);
				n++;
				if (n % 200 == 199)
					drain();
			end
			if ($urandom_range(0, 3) != 0)
				idle_sender($urandom_range(1, 8));
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("scancode_to_hid_report_core regression: pass");
		else
			$display("scancode_to_hid_report_core regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("scancode_to_hid_report_core regression: fail");
		$finish;
	end

endmodule
